// ===== rtl/pstbl_pkg.sv =====
// Shared constants, codes and types of the per-source token bucket limiter.
package pstbl_pkg;

  // Bucket table geometry
  localparam int unsigned ENTRIES = 256;
  localparam int unsigned IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CNT_W   = $clog2(ENTRIES + 1);

  // Packet and time constants
  localparam logic [15:0] MIN_PACKET_BYTES = 16'd34;
  localparam logic [30:0] NS_PER_SECOND    = 31'd1000000000;

  // Rounded-up 2^75 / 5^9: x / 10^9 == ((x >> 9) * SEC_RECIP) >> 75 for any 64-bit x
  localparam logic [54:0] SEC_RECIP = 55'h44B82FA09B5A53;

  // Register reset values
  localparam logic [31:0] CAPACITY_RST = 32'd10000;
  localparam logic [23:0] RATE_RST     = 24'd10000;
  localparam logic [31:0] INTERVAL_RST = 32'd10000000;

  // Register indexes on the configuration port
  typedef enum logic [1:0] {
    REG_CAPACITY = 2'd0,
    REG_RATE     = 2'd1,
    REG_INTERVAL = 2'd2
  } reg_index_t;

  // Verdict codes
  typedef enum logic [2:0] {
    STS_PASS   = 3'd0,
    STS_RATE   = 3'd1,
    STS_SHORT  = 3'd2,
    STS_NEW    = 3'd3,
    STS_FULL   = 3'd4
  } status_t;

  // Sequencer states
  typedef enum logic [10:0] {
    S_IDLE     = 11'b00000000001,
    S_SCAN     = 11'b00000000010,
    S_INSERT   = 11'b00000000100,
    S_EVAL     = 11'b00000001000,
    S_MUL_LO   = 11'b00000010000,
    S_MUL_HI   = 11'b00000100000,
    S_DIV_INIT = 11'b00001000000,
    S_DIV      = 11'b00010000000,
    S_SUM      = 11'b00100000000,
    S_UPDATE   = 11'b01000000000,
    S_DONE     = 11'b10000000000
  } state_t;

endpackage

// ===== rtl/per_source_token_bucket_limiter.sv =====
// Per-source token bucket limiter: table scan, refill arithmetic and verdict.
// A short packet goes straight to the output; a miss reads one key a cycle over all
// ENTRIES, then inserts and outputs; a hit at entry k ends the scan there, and a refill
// adds the multiply, divide and clamp states. One request at a time, the next taken the
// cycle after the verdict, and output stalls hold it off.
// Reset (synchronous) clears all valid bits at once and restores register defaults.
module per_source_token_bucket_limiter (
  input  logic        clk,
  input  logic        rst,
  // request channel
  input  logic        req_valid,
  output logic        req_stall,
  input  logic [31:0] source_addr,
  input  logic [15:0] packet_length,
  input  logic [63:0] now_ns,
  // verdict channel
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output logic        drop,
  output logic [2:0]  status,
  // configuration port
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int unsigned IW = pstbl_pkg::IDX_W;
  localparam int unsigned CW = pstbl_pkg::CNT_W;

  // Configuration registers
  logic [31:0] bucket_capacity;
  logic [23:0] refill_rate;
  logic [31:0] refill_interval_ns;

  // Sequencer and request registers
  pstbl_pkg::state_t  state;
  logic [31:0]        addr_r;
  logic [63:0]        now_r;

  // Scan control
  logic [CW-1:0]      scan_idx;
  logic               rd_pend;
  logic [IW-1:0]      rd_idx;
  logic               rd_vld;
  logic               free_found;
  logic [IW-1:0]      free_slot;
  logic [IW-1:0]      hit_slot;
  logic [pstbl_pkg::ENTRIES-1:0] valid_bits;

  // Bucket arithmetic
  logic [31:0]        before_r;
  logic [63:0]        elapsed_r;
  logic               refill;
  logic [55:0]        prod_lo;
  logic [31:0]        prod_hi;
  logic [63:0]        dividend;
  logic [109:0]       acc;
  logic [1:0]         div_cnt;
  logic [31:0]        new_tok;

  // Pending verdict
  logic               res_drop;
  pstbl_pkg::status_t res_status;

  // Memories
  logic [31:0] key_mem  [pstbl_pkg::ENTRIES];
  logic [31:0] tok_mem  [pstbl_pkg::ENTRIES];
  logic [63:0] time_mem [pstbl_pkg::ENTRIES];
  logic [31:0] key_q;
  logic [31:0] tok_q;
  logic [63:0] time_q;

  // Combinational helpers
  logic [IW-1:0] rd_addr;
  logic [IW-1:0] mem_waddr;
  logic          key_we;
  logic          tok_we;
  logic          time_we;
  logic [31:0]   tok_wdata;
  logic [31:0]   upd_base;
  logic [31:0]   upd_tokens;
  logic          scan_hit;
  logic          scan_last;
  logic [31:0]   mul_a;
  logic [31:0]   mul_b;
  logic [63:0]   mul_out;
  logic [109:0]  rcp_term;
  logic [63:0]   sum;
  logic          req_take;

  assign req_stall = (state != pstbl_pkg::S_IDLE);
  assign req_take  = req_valid && !req_stall;
  assign rd_addr   = scan_idx[IW-1:0];
  assign scan_hit  = rd_pend && rd_vld && (key_q == addr_r);
  assign scan_last = (rd_idx == IW'(pstbl_pkg::ENTRIES - 1));

  // Share one 32x32 multiplier: rate by the elapsed halves, then the reciprocal partials.
  // The divide by one second takes the dividend shifted right by 9, multiplies it by the
  // reciprocal in four 32-bit pieces and keeps the product from bit 75 up.
  always_comb begin
    mul_a    = {8'd0, refill_rate};
    mul_b    = elapsed_r[31:0];
    rcp_term = {46'd0, mul_out};
    case (state)
      pstbl_pkg::S_MUL_HI: begin
        mul_b = elapsed_r[63:32];
      end
      pstbl_pkg::S_DIV: begin
        case (div_cnt)
          2'd0: begin
            mul_a    = dividend[40:9];
            mul_b    = pstbl_pkg::SEC_RECIP[31:0];
            rcp_term = {46'd0, mul_out};
          end
          2'd1: begin
            mul_a    = dividend[40:9];
            mul_b    = {9'd0, pstbl_pkg::SEC_RECIP[54:32]};
            rcp_term = {14'd0, mul_out, 32'd0};
          end
          2'd2: begin
            mul_a    = {9'd0, dividend[63:41]};
            mul_b    = pstbl_pkg::SEC_RECIP[31:0];
            rcp_term = {14'd0, mul_out, 32'd0};
          end
          default: begin
            mul_a    = {9'd0, dividend[63:41]};
            mul_b    = {9'd0, pstbl_pkg::SEC_RECIP[54:32]};
            rcp_term = {mul_out[45:0], 64'd0};
          end
        endcase
      end
      default: begin
        mul_b = elapsed_r[31:0];
      end
    endcase
  end

  assign mul_out   = 64'(mul_a) * 64'(mul_b);

  // Refill sum; the quotient stays below 2^35, so no wrap
  assign sum       = {32'd0, before_r} + {29'd0, acc[109:75]};

  // Token count after refill and take
  assign upd_base   = refill ? new_tok : before_r;
  assign upd_tokens = ((before_r != 32'd0) && (upd_base != 32'd0)) ? upd_base - 32'd1
                                                                    : upd_base;

  // Select memory write port
  always_comb begin
    mem_waddr = hit_slot;
    key_we    = 1'b0;
    tok_we    = 1'b0;
    time_we   = 1'b0;
    tok_wdata = upd_tokens;
    case (state)
      pstbl_pkg::S_INSERT: begin
        mem_waddr = free_slot;
        key_we    = free_found;
        tok_we    = free_found;
        time_we   = free_found;
        tok_wdata = (bucket_capacity != 32'd0) ? bucket_capacity - 32'd1 : 32'd0;
      end
      pstbl_pkg::S_UPDATE: begin
        tok_we  = 1'b1;
        time_we = refill;
      end
      default: begin
        mem_waddr = hit_slot;
      end
    endcase
  end

  // Bucket table memories
  always_ff @(posedge clk) begin
    if (key_we) key_mem[mem_waddr] <= addr_r;
    if (tok_we) tok_mem[mem_waddr] <= tok_wdata;
    if (time_we) time_mem[mem_waddr] <= now_r;
    key_q  <= key_mem[rd_addr];
    tok_q  <= tok_mem[rd_addr];
    time_q <= time_mem[rd_addr];
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_capacity    <= pstbl_pkg::CAPACITY_RST;
      refill_rate        <= pstbl_pkg::RATE_RST;
      refill_interval_ns <= pstbl_pkg::INTERVAL_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        pstbl_pkg::REG_CAPACITY: bucket_capacity    <= cfg_data;
        pstbl_pkg::REG_RATE:     refill_rate        <= cfg_data[23:0];
        pstbl_pkg::REG_INTERVAL: refill_interval_ns <= cfg_data;
        default: ;
      endcase
    end
  end

  // Verdict valid: raise when a verdict is loaded, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (state == pstbl_pkg::S_DONE && (!rsp_valid || !rsp_stall)) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= pstbl_pkg::S_IDLE;
      valid_bits <= '0;
      rd_pend    <= 1'b0;
    end else begin
      case (state)
        pstbl_pkg::S_IDLE: begin
          if (req_take) begin
            addr_r     <= source_addr;
            now_r      <= now_ns;
            scan_idx   <= '0;
            rd_pend    <= 1'b0;
            free_found <= 1'b0;
            if (packet_length < pstbl_pkg::MIN_PACKET_BYTES) begin
              res_drop   <= 1'b1;
              res_status <= pstbl_pkg::STS_SHORT;
              state      <= pstbl_pkg::S_DONE;
            end else begin
              state <= pstbl_pkg::S_SCAN;
            end
          end
        end

        pstbl_pkg::S_SCAN: begin
          // issue the next read
          if (scan_idx < CW'(pstbl_pkg::ENTRIES)) begin
            rd_idx   <= scan_idx[IW-1:0];
            rd_vld   <= valid_bits[scan_idx[IW-1:0]];
            scan_idx <= scan_idx + CW'(1);
          end
          // compare the returned entry
          if (scan_hit) begin
            hit_slot  <= rd_idx;
            before_r  <= tok_q;
            elapsed_r <= now_r - time_q;
            rd_pend   <= 1'b0;
            state     <= pstbl_pkg::S_EVAL;
          end else begin
            if (rd_pend && !rd_vld && !free_found) begin
              free_found <= 1'b1;
              free_slot  <= rd_idx;
            end
            if (rd_pend && scan_last) begin
              rd_pend <= 1'b0;
              state   <= pstbl_pkg::S_INSERT;
            end else begin
              rd_pend <= (scan_idx < CW'(pstbl_pkg::ENTRIES));
            end
          end
        end

        pstbl_pkg::S_INSERT: begin
          if (free_found) begin
            valid_bits[free_slot] <= 1'b1;
            res_status            <= pstbl_pkg::STS_NEW;
          end else begin
            res_status <= pstbl_pkg::STS_FULL;
          end
          res_drop <= 1'b0;
          state    <= pstbl_pkg::S_DONE;
        end

        pstbl_pkg::S_EVAL: begin
          if (elapsed_r > {32'd0, refill_interval_ns}) begin
            refill <= 1'b1;
            state  <= pstbl_pkg::S_MUL_LO;
          end else begin
            refill <= 1'b0;
            state  <= pstbl_pkg::S_UPDATE;
          end
        end

        pstbl_pkg::S_MUL_LO: begin
          prod_lo <= mul_out[55:0];
          state   <= pstbl_pkg::S_MUL_HI;
        end

        pstbl_pkg::S_MUL_HI: begin
          prod_hi <= mul_out[31:0];
          state   <= pstbl_pkg::S_DIV_INIT;
        end

        pstbl_pkg::S_DIV_INIT: begin
          dividend <= {8'd0, prod_lo} + {prod_hi, 32'd0};
          acc      <= '0;
          div_cnt  <= '0;
          state    <= pstbl_pkg::S_DIV;
        end

        pstbl_pkg::S_DIV: begin
          // accumulate one reciprocal partial product a cycle
          acc     <= acc + rcp_term;
          div_cnt <= div_cnt + 2'd1;
          if (div_cnt == 2'd3) state <= pstbl_pkg::S_SUM;
        end

        pstbl_pkg::S_SUM: begin
          // clamp to capacity
          new_tok <= (sum < {32'd0, bucket_capacity}) ? sum[31:0] : bucket_capacity;
          state   <= pstbl_pkg::S_UPDATE;
        end

        pstbl_pkg::S_UPDATE: begin
          if (before_r != 32'd0) begin
            res_drop   <= 1'b0;
            res_status <= pstbl_pkg::STS_PASS;
          end else begin
            res_drop   <= 1'b1;
            res_status <= pstbl_pkg::STS_RATE;
          end
          state <= pstbl_pkg::S_DONE;
        end

        pstbl_pkg::S_DONE: begin
          // hold until the verdict register is free
          if (!rsp_valid || !rsp_stall) begin
            drop   <= res_drop;
            status <= res_status;
            state  <= pstbl_pkg::S_IDLE;
          end
        end

        default: begin
          state <= pstbl_pkg::S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== tb/sv/per_source_token_bucket_limiter_tb.sv =====
// Testbench for the per-source token bucket limiter: directed corners, random traffic, checks.
module per_source_token_bucket_limiter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Index that no register answers to
  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int unsigned POOL_SIZE = 16;

  typedef struct packed {
    logic               drop;
    pstbl_pkg::status_t status;
  } verdict_t;

  logic        clk;
  logic        rst;
  logic        req_valid;
  logic        req_stall;
  logic [31:0] source_addr;
  logic [15:0] packet_length;
  logic [63:0] now_ns;
  logic        rsp_valid;
  logic        rsp_stall;
  logic        drop;
  logic [2:0]  status;
  logic        cfg_write;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  per_source_token_bucket_limiter u_top (.*);

  // Expected verdicts in request order
  verdict_t verdict_q[$];
  int unsigned fault_count;

  // Bucket table and registers as the block should hold them
  logic [31:0] cap_cfg;
  logic [23:0] rate_cfg;
  logic [31:0] ival_cfg;
  logic        bkt_used   [pstbl_pkg::ENTRIES];
  logic [31:0] bkt_src    [pstbl_pkg::ENTRIES];
  logic [31:0] bkt_tokens [pstbl_pkg::ENTRIES];
  logic [63:0] bkt_stamp  [pstbl_pkg::ENTRIES];
  int unsigned bkt_count;

  // Stimulus state
  logic [31:0] src_pool [POOL_SIZE];
  logic [63:0] clock_ns;
  logic        req_live;
  int unsigned send_idle_pct;
  int unsigned rsp_stall_pct;
  int unsigned hold_len;
  int unsigned hold_left;

  // Phase settings for the random traffic: capacity, rate, interval
  logic [31:0] phase_cap  [8] = '{32'd10000, 32'd3, 32'd1, 32'hFFFF_FFFF,
                                  32'd5, 32'd2, 32'd0, 32'd8};
  logic [31:0] phase_rate [8] = '{32'd10000, 32'd1000, 32'd0, 32'h00FF_FFFF,
                                  32'd16777215, 32'd500, 32'd1000, 32'd2000000};
  logic [31:0] phase_ival [8] = '{32'd10000000, 32'd1000000, 32'd0, 32'hFFFF_FFFF,
                                  32'd100, 32'd3000000, 32'd1000, 32'd1000};

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic logic [63:0] rand64();
    return {32'($urandom), 32'($urandom)};
  endfunction

  function automatic void log_fault(input string msg);
    fault_count++;
    if (fault_count <= 10) $display("ERROR @%0t: %s", $realtime, msg);
  endfunction

  // Compute the verdict for one request and update the bucket table
  function automatic verdict_t rate_verdict(input logic [31:0] src, input logic [15:0] len,
                                            input logic [63:0] stamp);
    int hit;
    int vacant;
    logic [31:0] prior;
    logic [63:0] elapsed;
    logic [63:0] gain;
    logic [63:0] sum;
    verdict_t v;
    hit = -1;
    vacant = -1;
    v.drop = 1'b0;
    v.status = pstbl_pkg::STS_PASS;
    if (len < pstbl_pkg::MIN_PACKET_BYTES) begin
      v.drop = 1'b1;
      v.status = pstbl_pkg::STS_SHORT;
      return v;
    end
    for (int i = 0; i < pstbl_pkg::ENTRIES; i++) begin
      if (bkt_used[i]) begin
        if (hit < 0 && bkt_src[i] == src) hit = i;
      end else if (vacant < 0) begin
        vacant = i;
      end
    end
    // Unknown source: claim the first free bucket or pass untracked
    if (hit < 0) begin
      if (vacant < 0) begin
        v.status = pstbl_pkg::STS_FULL;
        return v;
      end
      bkt_used[vacant] = 1'b1;
      bkt_src[vacant] = src;
      bkt_tokens[vacant] = (cap_cfg != 0) ? cap_cfg - 32'd1 : 32'd0;
      bkt_stamp[vacant] = stamp;
      bkt_count++;
      v.status = pstbl_pkg::STS_NEW;
      return v;
    end
    // Refill past the interval; the verdict uses the count from before
    prior = bkt_tokens[hit];
    elapsed = stamp - bkt_stamp[hit];
    if (elapsed > {32'd0, ival_cfg}) begin
      gain = ({40'd0, rate_cfg} * elapsed) / 64'(pstbl_pkg::NS_PER_SECOND);
      sum = {32'd0, prior} + gain;
      bkt_tokens[hit] = (sum < {32'd0, cap_cfg}) ? sum[31:0] : cap_cfg;
      bkt_stamp[hit] = stamp;
    end
    if (prior != 0) begin
      if (bkt_tokens[hit] != 0) bkt_tokens[hit] = bkt_tokens[hit] - 32'd1;
    end else begin
      v.drop = 1'b1;
      v.status = pstbl_pkg::STS_RATE;
    end
    return v;
  endfunction

  // Advance the packet clock: mostly small steps, sometimes back or a jump
  function automatic logic [63:0] next_stamp();
    logic [63:0] span;
    int unsigned pick;
    span = {32'd0, ival_cfg} / 8 + 64'd2;
    pick = $urandom_range(99);
    if (pick < 75) clock_ns = clock_ns + (rand64() % span);
    else if (pick < 85) clock_ns = clock_ns + 64'($urandom_range(3));
    else if (pick < 90) clock_ns = clock_ns - 64'($urandom_range(5000));
    else if (pick < 95) clock_ns = rand64();
    else clock_ns = clock_ns + {32'd0, ival_cfg} + 64'($urandom_range(1));
    return clock_ns;
  endfunction

  // Verdict checker
  always @(posedge clk) begin : check_verdicts
    verdict_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (verdict_q.size() == 0) begin
        log_fault($sformatf("unexpected verdict drop=%0b status=%0d", drop, status));
      end else begin
        want = verdict_q.pop_front();
        if (drop !== want.drop || status !== want.status)
          log_fault($sformatf("verdict mismatch: expected drop=%0b status=%0d, %s",
                              want.drop, want.status,
                              $sformatf("got drop=%0b status=%0d", drop, status)));
      end
    end
  end

  // Verdict receiver: random stalls, plus a long hold-off on request
  initial begin
    rsp_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_len != 0) begin
        hold_left = hold_len;
        hold_len = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        rsp_stall <= 1'b1;
      end else begin
        rsp_stall <= (rsp_stall_pct != 0) && ($urandom_range(99) < rsp_stall_pct);
      end
    end
  end

  // Offer one request; hold it until accepted, then record its verdict
  task automatic offer_request(input logic [31:0] src, input logic [15:0] len,
                               input logic [63:0] stamp);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      if (req_live) req_valid <= 1'b0;
      req_live = 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    req_valid <= 1'b1;
    req_live = 1'b1;
    source_addr <= src;
    packet_length <= len;
    now_ns <= stamp;
    do @(posedge clk); while (req_stall);
    verdict_q.push_back(rate_verdict(src, len, stamp));
  endtask

  // Drop valid and wait until every verdict is back
  task automatic wait_verdicts_drained();
    if (req_live) req_valid <= 1'b0;
    req_live = 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      pstbl_pkg::REG_CAPACITY: cap_cfg = data;
      pstbl_pkg::REG_RATE:     rate_cfg = data[23:0];
      pstbl_pkg::REG_INTERVAL: ival_cfg = data;
      default: ;
    endcase
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_settings(input logic [31:0] cap, input logic [31:0] rate,
                                input logic [31:0] ival);
    wait_verdicts_drained();
    write_reg(pstbl_pkg::REG_CAPACITY, cap);
    write_reg(pstbl_pkg::REG_RATE, rate);
    write_reg(pstbl_pkg::REG_INTERVAL, ival);
  endtask

  task automatic set_idling(input int unsigned send_pct, input int unsigned rsp_pct);
    send_idle_pct = send_pct;
    rsp_stall_pct = rsp_pct;
  endtask

  // Short packets, new entries, extremes of address, length and time
  task automatic test_short_and_new();
    offer_request(32'h0A00_0001, 16'd0, 64'd1000);
    offer_request(32'h0A00_0001, 16'd33, 64'd1000);
    offer_request(32'h0A00_0001, 16'd34, 64'd1000);
    offer_request(32'h0A00_0001, 16'hFFFF, 64'd1005);
    offer_request(32'h0000_0000, 16'd1518, 64'd1000);
    offer_request(32'hFFFF_FFFF, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    // time wraps to zero: elapsed of one, no refill
    offer_request(32'hFFFF_FFFF, 16'd60, 64'd0);
  endtask

  // Refill threshold and a clock that steps back
  task automatic test_refill_edges();
    offer_request(32'h0A00_0001, 16'd100, 64'd1000 + 64'd10000000);
    offer_request(32'h0A00_0001, 16'd100, 64'd1000 + 64'd10000001);
    offer_request(32'h0A00_0001, 16'd100, 64'd500);
  endtask

  // Zero capacity: new entry starts empty; a refill can empty a bucket
  task automatic test_zero_capacity();
    apply_settings(32'd0, 32'd10000, 32'd10000000);
    offer_request(32'h0B00_0002, 16'd64, 64'd2000);
    offer_request(32'h0B00_0002, 16'd64, 64'd2001);
    offer_request(32'h0A00_0001, 16'd64, 64'd900000000);
    offer_request(32'h0A00_0001, 16'd64, 64'd900000001);
  endtask

  // Capacity lowered below a stored count: clamp only on refill
  task automatic test_capacity_lowered();
    apply_settings(32'hFFFF_FFFF, 32'd10000, 32'd10000000);
    offer_request(32'h0C00_0003, 16'd64, 64'd5000);
    wait_verdicts_drained();
    write_reg(pstbl_pkg::REG_CAPACITY, 32'd2);
    offer_request(32'h0C00_0003, 16'd64, 64'd5001);
    offer_request(32'h0C00_0003, 16'd64, 64'd30000000);
    offer_request(32'h0C00_0003, 16'd64, 64'd30000000);
    offer_request(32'h0C00_0003, 16'd64, 64'd30000000);
  endtask

  // Register extremes, bits above a register width, an index with no register
  task automatic test_register_extremes();
    wait_verdicts_drained();
    write_reg(pstbl_pkg::REG_CAPACITY, 32'd1);
    write_reg(pstbl_pkg::REG_RATE, 32'hFFFF_FFFF);
    write_reg(pstbl_pkg::REG_INTERVAL, 32'd0);
    write_reg(REG_UNUSED, 32'h1234_5678);
    offer_request(32'h0D00_0004, 16'd64, 64'd7000);
    offer_request(32'h0D00_0004, 16'd64, 64'd7001);
    offer_request(32'h0D00_0004, 16'd64, 64'd7100);
    offer_request(32'h0D00_0004, 16'd64, 64'd7100);
    apply_settings(32'd3, 32'd0, 32'hFFFF_FFFF);
    offer_request(32'h0D00_0004, 16'd64, 64'd7099);
  endtask

  // Random packets over a small source pool with some fresh sources
  task automatic test_random_traffic(input int unsigned count);
    logic [31:0] src;
    logic [15:0] len;
    int unsigned pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      src = (pick < 12) ? $urandom : src_pool[$urandom_range(POOL_SIZE - 1)];
      pick = $urandom_range(99);
      if (pick < 15) len = 16'($urandom_range(33));
      else if (pick < 20) len = 16'($urandom);
      else len = 16'($urandom_range(1518, 34));
      offer_request(src, len, next_stamp());
      // now and then pause until every verdict is back
      if ($urandom_range(49) == 0) wait_verdicts_drained();
    end
  endtask

  // Long verdict hold-off while requests keep coming
  task automatic test_verdict_backpressure();
    wait_verdicts_drained();
    set_idling(0, 0);
    hold_len = 3000;
    for (int n = 0; n < 6; n++)
      offer_request(src_pool[n], (n % 2 == 0) ? 16'd20 : 16'd200, next_stamp());
    wait_verdicts_drained();
  endtask

  // Fill every bucket, then send untracked sources and mixed traffic
  task automatic test_table_full();
    apply_settings(32'd4, 32'd3000, 32'd500000);
    set_idling(16, 16);
    while (bkt_count < pstbl_pkg::ENTRIES) offer_request($urandom, 16'd64, next_stamp());
    for (int n = 0; n < 10; n++) offer_request($urandom, 16'd100, next_stamp());
    test_random_traffic(150);
  endtask

  initial begin
    rst = 1'b1;
    req_valid = 1'b0;
    source_addr = '0;
    packet_length = '0;
    now_ns = '0;
    cfg_write = 1'b0;
    cfg_index = pstbl_pkg::REG_CAPACITY;
    cfg_data = '0;
    req_live = 1'b0;
    fault_count = 0;
    hold_len = 0;
    hold_left = 0;
    clock_ns = 64'd1000;
    set_idling(0, 0);
    cap_cfg = pstbl_pkg::CAPACITY_RST;
    rate_cfg = pstbl_pkg::RATE_RST;
    ival_cfg = pstbl_pkg::INTERVAL_RST;
    bkt_count = 0;
    for (int i = 0; i < pstbl_pkg::ENTRIES; i++) bkt_used[i] = 1'b0;
    for (int i = 0; i < POOL_SIZE; i++) src_pool[i] = $urandom;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_short_and_new();
    test_refill_edges();
    test_zero_capacity();
    test_capacity_lowered();
    test_register_extremes();
    for (int p = 0; p < 8; p++) begin
      apply_settings(phase_cap[p], phase_rate[p], phase_ival[p]);
      case (p % 4)
        0: set_idling(0, 0);
        1: set_idling(49, 0);
        2: set_idling(0, 49);
        default: set_idling(16, 16);
      endcase
      test_random_traffic(150);
    end
    test_verdict_backpressure();
    test_table_full();

    // Let any stray verdict show up before the call
    wait_verdicts_drained();
    repeat (400) @(posedge clk);
    if (fault_count == 0 && verdict_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/pstbl_pkg.sv
rtl/per_source_token_bucket_limiter.sv
tb/sv/per_source_token_bucket_limiter_tb.sv
